// File: hdl/per_site_combined_lcg_shuffle_rng_defines.svh
// -----------------------------------------------------------------------------
// per_site_combined_lcg_shuffle_rng_defines.svh
// Assertion macros shared by the per-site generator RTL. They expect clk and
// arst_n in the scope where they are used.
// -----------------------------------------------------------------------------
`ifndef PER_SITE_COMBINED_LCG_SHUFFLE_RNG_DEFINES_SVH
`define PER_SITE_COMBINED_LCG_SHUFFLE_RNG_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PSRNG_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSRNG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error(msg);

`endif

// File: hdl/psrng_pkg.sv
// -----------------------------------------------------------------------------
// psrng_pkg
// Types and constants of the per-site combined LCG generator with shuffle.
// -----------------------------------------------------------------------------
package psrng_pkg;

	// Command codes.
	localparam logic CMD_INIT = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	// First LCG: modulus 2^31 - 85, multiplier 40014.
	localparam logic [30:0] MOD1  = 31'd2147483563;
	localparam logic [15:0] MUL1  = 16'd40014;
	localparam logic [7:0]  FOLD1 = 8'd85;

	// Second LCG: modulus 2^31 - 249, multiplier 40692.
	localparam logic [30:0] MOD2  = 31'd2147483399;
	localparam logic [15:0] MUL2  = 16'd40692;
	localparam logic [7:0]  FOLD2 = 8'd249;

	// Combination and output bounds.
	localparam logic [30:0] MODM1      = 31'd2147483562;
	localparam logic [30:0] CLIP_BOUND = 31'd2147483305;
	localparam logic [30:0] HALF_BOUND = 31'd1073741782;

	// Input item of the request channel.
	typedef struct packed {
		logic        command;
		logic [7:0]  site;
		logic [23:0] global_index;
	} request_t;

	// Result item of the result channel.
	typedef struct packed {
		logic [30:0] raw_value;
		logic [30:0] deviate_numerator;
		logic        sign_negative;
	} result_t;

	// One entry of the per-site state memory.
	typedef struct packed {
		logic [30:0] first_lcg;
		logic [30:0] second_lcg;
		logic [30:0] last_output;
	} site_word_t;

	// Step request and response of the LCG pair unit.
	typedef struct packed {
		logic        valid;
		logic [30:0] x1;
		logic [30:0] x2;
	} lcg_req_t;

	typedef struct packed {
		logic        valid;
		logic [30:0] y1;
		logic [30:0] y2;
	} lcg_rsp_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_ISSUE,
		ST_SEED_WAIT,
		ST_DRAW_READ,
		ST_DRAW_START,
		ST_DRAW_WAIT,
		ST_DRAW_TREAD,
		ST_DRAW_WB,
		ST_DRAW_OUT
	} state_t;

endpackage

// File: hdl/psrng_stream_if.sv
// -----------------------------------------------------------------------------
// psrng_stream_if
// Valid/ready channel carrying one payload of a given type per transaction.
// -----------------------------------------------------------------------------
interface psrng_stream_if #(
	parameter type data_t = logic
) ();
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/psrng_lcg_pair.sv
// -----------------------------------------------------------------------------
// psrng_lcg_pair
// Three-stage pipeline that advances both LCGs by one step: multiply, then
// two folds of the high part using 2^31 = c (mod 2^31 - c), then one subtract.
// -----------------------------------------------------------------------------
module psrng_lcg_pair (
	input  logic                clk,
	input  logic                arst_n,
	input  psrng_pkg::lcg_req_t req,
	output psrng_pkg::lcg_rsp_t rsp
);

	logic        v_s1, v_s2, v_s3;
	logic [46:0] p1_s1, p2_s1;
	logic [31:0] f1_s2, f2_s2;
	logic [30:0] y1_s3, y2_s3;

	// Second fold and final reduction into [0, m).
	function automatic logic [30:0] reduce(input logic [31:0] f, input logic [30:0] m,
		input logic [7:0] c);
		logic [31:0] g;
		g = {1'b0, f[30:0]} + (f[31] ? 32'(c) : 32'd0);
		return (g >= 32'(m)) ? 31'(g - 32'(m)) : g[30:0];
	endfunction

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Data path: product, first fold, reduction.
	always_ff @(posedge clk) begin
		p1_s1 <= 47'(req.x1) * 47'(psrng_pkg::MUL1);
		p2_s1 <= 47'(req.x2) * 47'(psrng_pkg::MUL2);
		f1_s2 <= 32'(p1_s1[46:31]) * 32'(psrng_pkg::FOLD1) + 32'(p1_s1[30:0]);
		f2_s2 <= 32'(p2_s1[46:31]) * 32'(psrng_pkg::FOLD2) + 32'(p2_s1[30:0]);
		y1_s3 <= reduce(f1_s2, psrng_pkg::MOD1, psrng_pkg::FOLD1);
		y2_s3 <= reduce(f2_s2, psrng_pkg::MOD2, psrng_pkg::FOLD2);
	end

	assign rsp.valid = v_s3;
	assign rsp.y1    = y1_s3;
	assign rsp.y2    = y2_s3;

endmodule

// File: hdl/psrng_slot_div.sv
// -----------------------------------------------------------------------------
// psrng_slot_div
// Reciprocal multiplication that turns the previous output into a shuffle-table
// slot, with the slot saturated at NTAB-1. The slot is taken from the
// registered product and holds until the next start.
// -----------------------------------------------------------------------------
module psrng_slot_div #(
	parameter int NTAB = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [30:0]               dividend,
	output logic                      done,
	output logic [$clog2(NTAB)-1:0]   slot
);

	localparam int     SLOT_W   = $clog2(NTAB);
	localparam int     QW       = SLOT_W + 1;
	localparam longint DIVISOR  = 1 + (longint'(2147483562) / NTAB);
	// Reciprocal scaled so that the quotient is exact for every 31-bit dividend.
	localparam int     REC_L    = $clog2(DIVISOR);
	localparam int     SHIFT    = 31 + REC_L;
	localparam longint RECIP    = ((longint'(1) << SHIFT) / DIVISOR) + 1;
	localparam logic [31:0]       RECIP_C  = 32'(RECIP);
	localparam logic [QW-1:0]     NTAB_Q   = QW'(NTAB);
	localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(NTAB - 1);

	logic          busy_q;
	logic [62:0]   prod_q;
	logic [QW-1:0] quo;

	// Busy for the one cycle in which the product is formed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= start;
		end
	end

	// Product of the dividend and the scaled reciprocal.
	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= 63'(dividend) * 63'(RECIP_C);
		end
	end

	assign quo  = QW'(prod_q >> SHIFT);
	assign done = !busy_q;
	assign slot = (quo >= NTAB_Q) ? SLOT_MAX : quo[SLOT_W-1:0];

endmodule

// File: hdl/per_site_combined_lcg_shuffle_rng.sv
// -----------------------------------------------------------------------------
// per_site_combined_lcg_shuffle_rng
// One combined two-LCG generator with a Bays-Durham shuffle table per site.
//
// The request channel takes one command per transaction: init seeds a site
// from base_seed plus global_index and fills its table, draw advances the
// site and returns one result transaction (raw value, clipped numerator of
// the deviate over 2147483563, and a sign). Commands for a site at or above
// SITES are taken and dropped. The cfg channel writes base_seed; it is
// always ready and should be written while no command is in flight.
// Commands are handled one at a time. A draw passes through site read,
// issue, the LCG pipeline, table read, write-back and result load, and the
// next command is taken once its result is loaded. An init runs its warm-up
// steps one after another, each waiting on the three-stage LCG pipeline, and
// the next command is taken after the last step. A stalled receiver holds the
// one output register; the block keeps working until the next result needs
// it. Reset clears control state and base_seed, not the memories.
// -----------------------------------------------------------------------------
`include "per_site_combined_lcg_shuffle_rng_defines.svh"

module per_site_combined_lcg_shuffle_rng #(
	parameter int SITES = 256,
	parameter int NTAB  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	psrng_stream_if.sink          request,
	psrng_stream_if.source        result,
	psrng_stream_if.sink          cfg
);

	localparam int SITE_AW   = (SITES > 1) ? $clog2(SITES) : 1;
	localparam int TAB_DEPTH = SITES * NTAB;
	localparam int TAB_AW    = $clog2(TAB_DEPTH);
	localparam int SLOT_W    = $clog2(NTAB);
	localparam int CNT_W     = $clog2(NTAB + 9);
	localparam logic [CNT_W-1:0] STEPS_C = CNT_W'(NTAB + 8);
	localparam logic [CNT_W-1:0] NTAB_C  = CNT_W'(NTAB);
	localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

	// Memories.
	psrng_pkg::site_word_t site_mem [SITES];
	logic [30:0]           tab_mem  [TAB_DEPTH];

	// Control state.
	psrng_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              lcg_done_q;
	logic              out_valid_q;
	logic [30:0]       base_seed_q;

	// Payload registers.
	logic [SITE_AW-1:0]    site_idx_q;
	logic [30:0]           x_q, a_q, b_q;
	psrng_pkg::site_word_t site_rd_q;
	logic [30:0]           tab_rd_q;
	psrng_pkg::result_t    res_q, out_data_q;

	// Combinational signals.
	logic                  accept, in_range;
	logic [15:0]           site_ext;
	logic [31:0]           seed_sum;
	logic [30:0]           seed;
	logic [CNT_W-1:0]      cnt_dec;
	logic [TAB_AW-1:0]     tab_base;
	psrng_pkg::lcg_req_t   lcg_req;
	psrng_pkg::lcg_rsp_t   lcg_rsp;
	logic                  div_start, div_done;
	logic [SLOT_W-1:0]     slot;
	logic                  site_re, site_we, tab_re, tab_we, out_load;
	logic [TAB_AW-1:0]     tab_raddr, tab_waddr;
	logic [30:0]           tab_wdata;
	psrng_pkg::site_word_t site_wdata;
	logic [30:0]           y, num;

	// Request decode and start value.
	assign accept   = request.valid && request.ready;
	assign site_ext = 16'(request.data.site);
	assign in_range = 17'(request.data.site) < 17'(SITES);
	assign seed_sum = 32'(base_seed_q) + 32'(request.data.global_index) + 32'd1;
	assign seed     = seed_sum[31] ? 31'd1 : seed_sum[30:0];
	assign cnt_dec  = cnt_q - ONE_C;
	assign tab_base = TAB_AW'(TAB_AW'(site_idx_q) * TAB_AW'(NTAB));

	// Shuffle combination and output shaping.
	always_comb begin
		if (tab_rd_q >= b_q) begin
			y = tab_rd_q - b_q;
		end else begin
			y = 31'(33'(tab_rd_q) + 33'(psrng_pkg::MODM1) - 33'(b_q));
		end
		num = (y > psrng_pkg::CLIP_BOUND) ? psrng_pkg::CLIP_BOUND : y;
	end

	// Configuration register.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_seed_q <= '0;
		end else if (cfg.valid) begin
			base_seed_q <= cfg.data;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			psrng_pkg::ST_IDLE: begin
				if (request.valid) begin
					if (!in_range) begin
						state_d = psrng_pkg::ST_IDLE;
					end else if (request.data.command == psrng_pkg::CMD_INIT) begin
						state_d = psrng_pkg::ST_SEED_ISSUE;
					end else begin
						state_d = psrng_pkg::ST_DRAW_READ;
					end
				end
			end
			psrng_pkg::ST_SEED_ISSUE: state_d = psrng_pkg::ST_SEED_WAIT;
			psrng_pkg::ST_SEED_WAIT: begin
				if (lcg_rsp.valid) begin
					state_d = (cnt_q == ONE_C) ? psrng_pkg::ST_IDLE
						: psrng_pkg::ST_SEED_ISSUE;
				end
			end
			psrng_pkg::ST_DRAW_READ:  state_d = psrng_pkg::ST_DRAW_START;
			psrng_pkg::ST_DRAW_START: state_d = psrng_pkg::ST_DRAW_WAIT;
			psrng_pkg::ST_DRAW_WAIT: begin
				if (lcg_done_q && div_done) begin
					state_d = psrng_pkg::ST_DRAW_TREAD;
				end
			end
			psrng_pkg::ST_DRAW_TREAD: state_d = psrng_pkg::ST_DRAW_WB;
			psrng_pkg::ST_DRAW_WB:    state_d = psrng_pkg::ST_DRAW_OUT;
			psrng_pkg::ST_DRAW_OUT: begin
				if (!out_valid_q || result.ready) begin
					state_d = psrng_pkg::ST_IDLE;
				end
			end
			default: state_d = psrng_pkg::ST_IDLE;
		endcase
	end

	// Output logic: memory strobes, unit starts and channel handshakes.
	always_comb begin
		request.ready = 1'b0;
		site_re       = 1'b0;
		site_we       = 1'b0;
		site_wdata    = '{first_lcg: a_q, second_lcg: b_q, last_output: y};
		tab_re        = 1'b0;
		tab_raddr     = tab_base + TAB_AW'(slot);
		tab_we        = 1'b0;
		tab_waddr     = tab_base + TAB_AW'(slot);
		tab_wdata     = a_q;
		lcg_req.valid = 1'b0;
		lcg_req.x1    = site_rd_q.first_lcg;
		lcg_req.x2    = site_rd_q.second_lcg;
		div_start     = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			psrng_pkg::ST_IDLE: request.ready = 1'b1;
			psrng_pkg::ST_SEED_ISSUE: begin
				lcg_req.valid = 1'b1;
				lcg_req.x1    = x_q;
			end
			psrng_pkg::ST_SEED_WAIT: begin
				// Only the last NTAB warm-up steps land in the table.
				tab_we     = lcg_rsp.valid && (cnt_q <= NTAB_C);
				tab_waddr  = tab_base + TAB_AW'(cnt_dec[SLOT_W-1:0]);
				tab_wdata  = lcg_rsp.y1;
				site_we    = lcg_rsp.valid && (cnt_q == ONE_C);
				site_wdata = '{first_lcg: lcg_rsp.y1, second_lcg: b_q,
					last_output: lcg_rsp.y1};
			end
			psrng_pkg::ST_DRAW_READ: site_re = 1'b1;
			psrng_pkg::ST_DRAW_START: begin
				lcg_req.valid = 1'b1;
				div_start     = 1'b1;
			end
			psrng_pkg::ST_DRAW_WAIT:  ;
			psrng_pkg::ST_DRAW_TREAD: tab_re = 1'b1;
			psrng_pkg::ST_DRAW_WB: begin
				tab_we  = 1'b1;
				site_we = 1'b1;
			end
			psrng_pkg::ST_DRAW_OUT: out_load = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= psrng_pkg::ST_IDLE;
			cnt_q       <= '0;
			lcg_done_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= STEPS_C;
			end else if (state_q == psrng_pkg::ST_SEED_WAIT && lcg_rsp.valid) begin
				cnt_q <= cnt_dec;
			end
			if (state_q == psrng_pkg::ST_DRAW_START) begin
				lcg_done_q <= 1'b0;
			end else if (state_q == psrng_pkg::ST_DRAW_WAIT && lcg_rsp.valid) begin
				lcg_done_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			site_idx_q <= site_ext[SITE_AW-1:0];
			x_q        <= seed;
			b_q        <= seed;
		end else if (state_q == psrng_pkg::ST_SEED_WAIT && lcg_rsp.valid) begin
			x_q <= lcg_rsp.y1;
		end else if (state_q == psrng_pkg::ST_DRAW_WAIT && lcg_rsp.valid) begin
			a_q <= lcg_rsp.y1;
			b_q <= lcg_rsp.y2;
		end
		if (state_q == psrng_pkg::ST_DRAW_WB) begin
			res_q.raw_value         <= y;
			res_q.deviate_numerator <= num;
			res_q.sign_negative     <= (num >= psrng_pkg::HALF_BOUND) ? 1'b0 : 1'b1;
		end
		if (out_load) begin
			out_data_q <= res_q;
		end
	end

	// Per-site state memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (site_we) begin
			site_mem[site_idx_q] <= site_wdata;
		end
		if (site_re) begin
			site_rd_q <= site_mem[site_idx_q];
		end
	end

	// Shuffle-table memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (tab_we) begin
			tab_mem[tab_waddr] <= tab_wdata;
		end
		if (tab_re) begin
			tab_rd_q <= tab_mem[tab_raddr];
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	// Arithmetic units.
	psrng_lcg_pair u_lcg (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (lcg_req),
		.rsp    (lcg_rsp)
	);

	psrng_slot_div #(
		.NTAB (NTAB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (site_rd_q.last_output),
		.done     (div_done),
		.slot     (slot)
	);

	// Checks.
	`PSRNG_ASSERT_IMPL(a_lcg_latency, lcg_req.valid, ##3 lcg_rsp.valid, "LCG response late")
	`PSRNG_ASSERT_IMPL(a_tread_ready, state_q == psrng_pkg::ST_DRAW_TREAD,
		lcg_done_q && div_done, "table read before step and slot are ready")
	`PSRNG_ASSERT_IMPL(a_result_source, $rose(result.valid),
		$past(state_q == psrng_pkg::ST_DRAW_OUT), "result without a draw")
	`PSRNG_ASSERT_IMPL(a_clip_order, result.valid,
		result.data.deviate_numerator <= result.data.raw_value, "clip above raw value")

endmodule

// File: tb/site_draw_predictor.sv
// -----------------------------------------------------------------------------
// site_draw_predictor
// Watches the request, result and seed channels of the per-site generator.
// It keeps its own copy of every site's two LCGs, last output and shuffle
// table, works out the result of each accepted draw, and compares each
// result transaction with the oldest outstanding prediction.
// -----------------------------------------------------------------------------
module site_draw_predictor #(
	parameter int SITES = 256,
	parameter int NTAB  = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	psrng_stream_if  request,
	psrng_stream_if  result,
	psrng_stream_if  cfg,
	output int       pending,
	output int       failures
);

	// Schrage decomposition of both moduli: m = a * q + r.
	localparam longint Q1 = 53668;
	localparam longint R1 = 12211;
	localparam longint Q2 = 52774;
	localparam longint R2 = 3791;
	// Width of one shuffle slot in output space.
	localparam longint SLOT_DIV = 1 + longint'(psrng_pkg::MODM1) / NTAB;

	logic [30:0]        seed_reg;
	logic [30:0]        lcg_a [SITES];
	logic [30:0]        lcg_b [SITES];
	logic [30:0]        prev_draw [SITES];
	logic [30:0]        shuffle_mem [SITES * NTAB];
	psrng_pkg::result_t pending_draws [$];
	int                 mismatch_count;

	// One multiplicative LCG step in Schrage form; result lies in [0, m).
	function automatic logic [30:0] lecuyer_step(input logic [30:0] x, input longint mul,
			input longint quo, input longint rem, input longint modulus);
		longint hi;
		longint lo;
		longint t;
		hi = longint'(x) / quo;
		lo = longint'(x) % quo;
		t = mul * lo - rem * hi;
		if (t < 0) begin
			t += modulus;
		end
		return t[30:0];
	endfunction

	// Seed a site and run the warm-up steps that fill its shuffle table.
	task automatic prime_site(input logic [7:0] site, input logic [23:0] gidx);
		logic [32:0] start;
		logic [30:0] x;
		int          base;
		base = int'(site) * NTAB;
		start = {2'b00, seed_reg} + {9'd0, gidx} + 33'd1;
		// A start value beyond the positive 32-bit range falls back to one.
		if (start > 33'h07FFF_FFFF) begin
			start = 33'd1;
		end
		x = start[30:0];
		lcg_b[site] = x;
		for (int j = NTAB + 7; j >= 0; j--) begin
			x = lecuyer_step(x, longint'(psrng_pkg::MUL1), Q1, R1, longint'(psrng_pkg::MOD1));
			if (j < NTAB) begin
				shuffle_mem[base + j] = x;
			end
		end
		lcg_a[site] = x;
		prev_draw[site] = shuffle_mem[base];
	endtask

	// Advance a site's generator and return the result it produces.
	function automatic psrng_pkg::result_t draw_site(input logic [7:0] site);
		logic [30:0]        a;
		logic [30:0]        b;
		logic [30:0]        y;
		longint             slot;
		longint             wrapped;
		int                 idx;
		psrng_pkg::result_t res;
		a = lecuyer_step(lcg_a[site], longint'(psrng_pkg::MUL1), Q1, R1,
			longint'(psrng_pkg::MOD1));
		b = lecuyer_step(lcg_b[site], longint'(psrng_pkg::MUL2), Q2, R2,
			longint'(psrng_pkg::MOD2));
		lcg_a[site] = a;
		lcg_b[site] = b;
		// The previous output picks the table slot.
		slot = longint'(prev_draw[site]) / SLOT_DIV;
		if (slot >= NTAB) begin
			slot = NTAB - 1;
		end
		idx = int'(site) * NTAB + int'(slot);
		wrapped = longint'(shuffle_mem[idx]) - longint'(b);
		if (wrapped < 0) begin
			wrapped += longint'(psrng_pkg::MODM1);
		end
		y = wrapped[30:0];
		shuffle_mem[idx] = a;
		prev_draw[site] = y;
		res.raw_value = y;
		res.deviate_numerator = (y > psrng_pkg::CLIP_BOUND) ? psrng_pkg::CLIP_BOUND : y;
		res.sign_negative = (res.deviate_numerator >= psrng_pkg::HALF_BOUND) ? 1'b0 : 1'b1;
		return res;
	endfunction

	// Compare one result transaction with the oldest prediction.
	task automatic check_result(input psrng_pkg::result_t got);
		psrng_pkg::result_t want;
		if (pending_draws.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("%0t: result with no draw outstanding: raw %0d num %0d neg %0b",
					$realtime, got.raw_value, got.deviate_numerator, got.sign_negative);
			end
		end else begin
			want = pending_draws.pop_front();
			if (got.raw_value !== want.raw_value
					|| got.deviate_numerator !== want.deviate_numerator
					|| got.sign_negative !== want.sign_negative) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("%0t: mismatch (exp/got) raw %0d/%0d num %0d/%0d neg %0b/%0b",
						$realtime, want.raw_value, got.raw_value, want.deviate_numerator,
						got.deviate_numerator, want.sign_negative, got.sign_negative);
				end
			end
		end
	endtask

	// Follow every transaction on the three channels. A seed written at the
	// same edge as a request only applies to later requests.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_reg = '0;
			pending_draws.delete();
		end else begin
			if (result.valid && result.ready) begin
				check_result(result.data);
			end
			if (request.valid && request.ready && int'(request.data.site) < SITES) begin
				if (request.data.command == psrng_pkg::CMD_INIT) begin
					prime_site(request.data.site, request.data.global_index);
				end else begin
					pending_draws.push_back(draw_site(request.data.site));
				end
			end
			if (cfg.valid && cfg.ready) begin
				seed_reg = cfg.data;
			end
		end
		pending <= pending_draws.size();
		failures <= mismatch_count;
	end

endmodule

// File: tb/testbench.sv
// -----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the per-site combined LCG generator. A directed
// part seeds sites at the edges of the start value (smallest, largest,
// equal to either modulus, past the positive range) and draws from them;
// random phases then mix inits and draws under fresh seeds while both
// channels stall at random and the receiver once holds off for a long time.
// -----------------------------------------------------------------------------
module testbench;

	localparam int SITES = 256;
	localparam int NTAB  = 32;
	// An init can still be running after the last draw has returned.
	localparam int SETTLE_CYCLES = 4 * (NTAB + 8) + 1 + 40;
	localparam int PRESSURE_AT     = 500;
	localparam int PRESSURE_CYCLES = 400;

	logic clk;
	logic arst_n;
	int   pending;
	int   fail_count;
	int   items_sent;
	int   n_inits;
	int   n_draws;
	int   seed_settings;
	bit   steady;
	bit   pressure_done;
	bit   site_live [SITES];
	logic [7:0] live_sites [$];

	psrng_stream_if #(.data_t(psrng_pkg::request_t)) request_ch ();
	psrng_stream_if #(.data_t(psrng_pkg::result_t))  result_ch ();
	psrng_stream_if #(.data_t(logic [30:0]))         cfg_ch ();

	per_site_combined_lcg_shuffle_rng #(.SITES(SITES), .NTAB(NTAB)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	site_draw_predictor #(.SITES(SITES), .NTAB(NTAB)) draw_predictor (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request_ch),
		.result  (result_ch),
		.cfg     (cfg_ch),
		.pending (pending),
		.failures(fail_count)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit.
	initial begin
		#2000000;
		$display("per_site_combined_lcg_shuffle_rng test failed");
		$finish;
	end

	// Result receiver: random stalls, one long hold-off, one stall-free stretch.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!pressure_done && items_sent >= PRESSURE_AT) begin
				pressure_done = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (PRESSURE_CYCLES) @(posedge clk);
			end
			result_ch.ready <= steady || ($urandom_range(0, 99) >= 10);
		end
	end

	// Offer one request transaction, at times with a random gap in front of it.
	task automatic issue(input logic cmd, input logic [7:0] site, input logic [23:0] gidx);
		psrng_pkg::request_t req;
		if (!steady && $urandom_range(0, 99) < 10) begin
			request_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req.command = cmd;
		req.site = site;
		req.global_index = gidx;
		request_ch.valid <= 1'b1;
		request_ch.data <= req;
		@(posedge clk);
		while (!request_ch.ready) @(posedge clk);
		items_sent++;
		if (cmd == psrng_pkg::CMD_INIT) begin
			n_inits++;
			if (!site_live[site]) begin
				site_live[site] = 1'b1;
				live_sites.push_back(site);
			end
		end else begin
			n_draws++;
		end
	endtask

	task automatic init_site(input logic [7:0] site, input logic [23:0] gidx);
		issue(psrng_pkg::CMD_INIT, site, gidx);
	endtask

	task automatic draw(input logic [7:0] site);
		issue(psrng_pkg::CMD_DRAW, site, 24'($urandom_range(0, 24'hFF_FFFF)));
	endtask

	// Wait until the block is idle, then write a new seed.
	task automatic write_seed(input logic [30:0] seed);
		request_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= seed;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		seed_settings++;
	endtask

	// Mostly draws on seeded sites, some of them on a few hot sites.
	task automatic random_phase(input int count);
		int hot;
		for (int k = 0; k < count; k++) begin
			if (live_sites.size() == 0 || $urandom_range(0, 99) < 15) begin
				init_site(8'($urandom_range(0, SITES - 1)),
					24'($urandom_range(0, 24'hFF_FFFF)));
			end else if ($urandom_range(0, 1) == 1) begin
				hot = (live_sites.size() < 4) ? live_sites.size() - 1 : 3;
				draw(live_sites[$urandom_range(0, hot)]);
			end else begin
				draw(live_sites[$urandom_range(0, live_sites.size() - 1)]);
			end
		end
	endtask

	// Stimulus and verdict.
	initial begin
		arst_n <= 1'b0;
		request_ch.valid <= 1'b0;
		request_ch.data <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Smallest start value and largest global index.
		write_seed(31'd0);
		init_site(8'd0, 24'd0);
		init_site(8'd255, 24'hFF_FFFF);
		draw(8'd0);
		draw(8'd0);
		draw(8'd255);
		draw(8'd0);
		draw(8'd255);
		// Start equal to the first modulus (stuck at zero) and just above it.
		write_seed(psrng_pkg::MOD1 - 31'd1);
		init_site(8'd1, 24'd0);
		init_site(8'd2, 24'd1);
		draw(8'd1);
		draw(8'd1);
		draw(8'd2);
		// Start equal to the second modulus.
		write_seed(psrng_pkg::MOD2 - 31'd1);
		init_site(8'd3, 24'd0);
		draw(8'd3);
		draw(8'd3);
		// Largest start value, and one step past it falls back to one.
		write_seed(31'h7FFF_FFFE);
		init_site(8'd4, 24'd0);
		init_site(8'd5, 24'd1);
		draw(8'd4);
		draw(8'd5);
		// Largest seed with the largest index also falls back to one.
		write_seed(31'h7FFF_FFFF);
		init_site(8'd6, 24'hFF_FFFF);
		draw(8'd6);
		draw(8'd6);
		draw(8'd0);

		// Random phases under fresh seeds; one of them runs without stalls.
		for (int p = 0; p < 5; p++) begin
			write_seed(31'($urandom()));
			steady = (p == 3);
			random_phase(245);
		end
		steady = 1'b0;

		request_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d init and %0d draw transactions under %0d seed settings.",
			n_inits, n_draws, seed_settings);
		$display("%0d distinct sites were seeded; %0d result mismatches seen.",
			live_sites.size(), fail_count);
		if (fail_count == 0) begin
			$display("per_site_combined_lcg_shuffle_rng test passed");
		end else begin
			$display("per_site_combined_lcg_shuffle_rng test failed");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/psrng_pkg.sv
hdl/psrng_stream_if.sv
hdl/psrng_lcg_pair.sv
hdl/psrng_slot_div.sv
hdl/per_site_combined_lcg_shuffle_rng.sv
tb/site_draw_predictor.sv
tb/testbench.sv
